[rtl/ostb_pkg.sv]
`default_nettype none

package ostb_pkg;

    localparam int TIME_W        = 32;
    localparam int MODE_W        = 2;
    localparam int TIDX_W        = 3;

    localparam int NUM_TIMERS_DEF = 8;

    // fired results reported per tick; further expired timers are only disarmed
    localparam int MAX_REPORTS   = 8;
    localparam int REP_CNT_W     = $clog2(MAX_REPORTS + 1);

    localparam logic [TIME_W-1:0] ALL_ONES = '1;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

endpackage

`default_nettype wire

[rtl/ostb_cmd_if.sv]
`default_nettype none

interface ostb_cmd_if
    import ostb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TIDX_W-1:0] timer_index;
    logic [TIME_W-1:0] amount;

    modport source (output valid, output mode, output timer_index, output amount,
                    input ready);
    modport sink   (input valid, input mode, input timer_index, input amount,
                    output ready);
endinterface

`default_nettype wire

[rtl/ostb_evt_if.sv]
`default_nettype none

interface ostb_evt_if
    import ostb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              fired;
    logic [TIDX_W-1:0] fired_index;
    logic [TIME_W-1:0] current_time;
    logic              last;

    modport source (output valid, output fired, output fired_index, output current_time,
                    output last, input ready);
    modport sink   (input valid, input fired, input fired_index, input current_time,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/ostb_ram.sv]
`default_nettype none

module ostb_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output      logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/one_shot_timer_bank.sv]
// Bank of NUM_TIMERS one-shot timers on one shared 32-bit millisecond clock.
// cmd channel (valid/ready): mode 0 advances the clock by amount, mode 1 arms
// timer timer_index with deadline clock + amount, mode 2 cancels a timer.
// evt channel (valid/ready): one beat per expired timer (fired=1, index order,
// at most 8 per tick), or a single fired=0 beat; last marks the final beat of
// each command. current_time is the clock after the command.
// A tick that does not reach the earliest deadline, mode 3, or an
// out-of-range index goes from idle straight to the finish state, which
// loads its beat into the output register. Arm, cancel and a tick that
// reaches the earliest deadline run a scan of the deadline RAM, one timer
// per cycle unless stalled by the output, through a single compare unit;
// with several expired timers the earlier fired beats leave during the scan.
// One command at a time: cmd.ready is high only while the sequencer is
// idle, so a new command is taken only after the last beat of the previous
// one has been loaded. A fired beat is held back one timer so that last
// can be set; if the receiver stalls when a new report arrives, the scan
// pauses (RAM read held) and no beat is dropped.
// Reset clears the clock to 0, disarms all timers and sets the earliest
// deadline to all ones; the deadline RAM is not cleared (used only when armed).
`default_nettype none

module one_shot_timer_bank
    import ostb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ostb_cmd_if.sink    cmd,
    ostb_evt_if.source  evt
);
    localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNTW = $clog2(NUM_TIMERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                 state_reg;
    logic [TIME_W-1:0]      clock_reg;
    logic [TIME_W-1:0]      earliest_reg;
    logic [NUM_TIMERS-1:0]  armed_reg;
    logic                   is_tick_reg;
    logic [CNTW-1:0]        scan_cnt_reg;
    logic                   cmp_valid_reg;
    logic [IDXW-1:0]        cmp_idx_reg;
    logic [TIME_W-1:0]      min_reg;
    logic [REP_CNT_W-1:0]   rep_cnt_reg;
    logic                   pend_valid_reg;
    logic [TIDX_W-1:0]      pend_idx_reg;
    logic                   out_valid_reg;
    logic                   out_fired_reg;
    logic [TIDX_W-1:0]      out_idx_reg;
    logic [TIME_W-1:0]      out_time_reg;
    logic                   out_last_reg;

    logic [TIME_W-1:0]      sum;
    logic                   idx_ok;
    logic [IDXW-1:0]        tidx;
    logic [TIME_W-1:0]      rdata;
    logic                   cur_armed;
    logic                   expired;
    logic                   hit;
    logic                   keep;
    logic                   rep;
    logic                   out_free;
    logic                   out_load;
    logic                   stall;
    logic                   advance;
    logic                   scan_more;
    logic                   scan_done;
    logic [TIME_W-1:0]      min_next;
    logic                   ram_we;
    logic                   ram_re;

    assign sum       = clock_reg + cmd.amount;
    assign idx_ok    = int'(cmd.timer_index) < NUM_TIMERS;
    assign tidx      = IDXW'(cmd.timer_index);

    assign cur_armed = armed_reg[cmp_idx_reg];
    assign expired   = is_tick_reg && (rdata <= clock_reg);
    assign hit       = cmp_valid_reg && cur_armed && expired;
    assign keep      = cmp_valid_reg && cur_armed && !expired;
    assign rep       = hit && (rep_cnt_reg < REP_CNT_W'(MAX_REPORTS));
    assign min_next  = (keep && (rdata < min_reg)) ? rdata : min_reg;

    assign out_free  = !out_valid_reg || evt.ready;
    // a new report displaces the held one, which needs a free output slot
    assign stall     = rep && pend_valid_reg && !out_free;
    assign advance   = (state_reg == ST_SCAN) && !stall;
    assign scan_more = scan_cnt_reg < CNTW'(NUM_TIMERS);
    assign scan_done = cmp_valid_reg && (cmp_idx_reg == IDXW'(NUM_TIMERS - 1));
    // output register gets a new beat this cycle
    assign out_load  = (advance && rep && pend_valid_reg) ||
                       ((state_reg == ST_FINISH) && out_free);

    assign ram_we    = cmd.valid && cmd.ready && (cmd.mode == MODE_ARM) && idx_ok;
    assign ram_re    = advance && scan_more;

    ostb_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_TIMERS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tidx),
        .wdata (sum),
        .re    (ram_re),
        .raddr (scan_cnt_reg[IDXW-1:0]),
        .rdata (rdata)
    );

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign evt.valid        = out_valid_reg;
    assign evt.fired        = out_fired_reg;
    assign evt.fired_index  = out_idx_reg;
    assign evt.current_time = out_time_reg;
    assign evt.last         = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clock_reg      <= '0;
            earliest_reg   <= ALL_ONES;
            armed_reg      <= '0;
            is_tick_reg    <= 1'b0;
            scan_cnt_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            min_reg        <= ALL_ONES;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_fired_reg  <= 1'b0;
            out_idx_reg    <= '0;
            out_time_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && evt.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        pend_valid_reg <= 1'b0;
                        rep_cnt_reg    <= '0;
                        min_reg        <= ALL_ONES;
                        scan_cnt_reg   <= '0;
                        cmp_valid_reg  <= 1'b0;
                        is_tick_reg    <= (cmd.mode == MODE_TICK);
                        case (cmd.mode)
                            MODE_TICK:
                            begin
                                clock_reg <= sum;
                                state_reg <= (sum >= earliest_reg) ? ST_SCAN : ST_FINISH;
                            end
                            MODE_ARM:
                            begin
                                if (idx_ok)
                                begin
                                    armed_reg[tidx] <= 1'b1;
                                    state_reg       <= ST_SCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            MODE_CANCEL:
                            begin
                                if (idx_ok)
                                begin
                                    armed_reg[tidx] <= 1'b0;
                                    state_reg       <= ST_SCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    if (advance)
                    begin
                        cmp_valid_reg <= scan_more;
                        cmp_idx_reg   <= scan_cnt_reg[IDXW-1:0];
                        if (scan_more)
                        begin
                            scan_cnt_reg <= scan_cnt_reg + CNTW'(1);
                        end
                        min_reg <= min_next;
                        if (hit)
                        begin
                            armed_reg[cmp_idx_reg] <= 1'b0;
                        end
                        if (rep)
                        begin
                            rep_cnt_reg    <= rep_cnt_reg + REP_CNT_W'(1);
                            pend_valid_reg <= 1'b1;
                            pend_idx_reg   <= TIDX_W'(cmp_idx_reg);
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_fired_reg <= 1'b1;
                                out_idx_reg   <= pend_idx_reg;
                                out_time_reg  <= clock_reg;
                                out_last_reg  <= 1'b0;
                            end
                        end
                        if (scan_done)
                        begin
                            earliest_reg <= min_next;
                            state_reg    <= ST_FINISH;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_fired_reg  <= pend_valid_reg;
                        out_idx_reg    <= pend_valid_reg ? pend_idx_reg : '0;
                        out_time_reg   <= clock_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[test/fired_event_checker.sv]
`timescale 1ns / 1ps

module fired_event_checker
    import ostb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ostb_cmd_if       cmd,
    ostb_evt_if       evt,
    output int        mismatches,
    output int        outstanding
);

    typedef struct packed {
        logic              fired;
        logic [TIDX_W-1:0] slot;
        logic [TIME_W-1:0] now;
        logic              last;
    } fire_beat_t;

    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] soonest_due;
    logic              armed  [NUM_TIMERS];
    logic [TIME_W-1:0] due_at [NUM_TIMERS];
    fire_beat_t        due_beats[$];
    int                err_total = 0;

    function automatic logic [TIME_W-1:0] min_armed_due();
        logic [TIME_W-1:0] m;
        m = ALL_ONES;
        for (int i = 0; i < NUM_TIMERS; i++)
            if (armed[i] && due_at[i] < m)
                m = due_at[i];
        return m;
    endfunction

    // Work out the beats one command produces and queue them in order.
    function automatic void apply_cmd(logic [MODE_W-1:0] mode, logic [TIDX_W-1:0] slot,
                                      logic [TIME_W-1:0] amount);
        int         hits;
        fire_beat_t b;
        hits = 0;
        if (mode == MODE_TICK)
        begin
            clock_ms = clock_ms + amount;
            if (clock_ms >= soonest_due)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (armed[i] && due_at[i] <= clock_ms)
                    begin
                        armed[i] = 1'b0;
                        if (hits < MAX_REPORTS)
                        begin
                            b = '{fired: 1'b1, slot: TIDX_W'(i), now: clock_ms, last: 1'b0};
                            due_beats.push_back(b);
                            hits++;
                        end
                    end
                end
                soonest_due = min_armed_due();
            end
        end
        else if (mode == MODE_ARM && slot < NUM_TIMERS)
        begin
            armed[slot]  = 1'b1;
            due_at[slot] = clock_ms + amount;
            soonest_due  = min_armed_due();
        end
        else if (mode == MODE_CANCEL && slot < NUM_TIMERS)
        begin
            armed[slot]  = 1'b0;
            due_at[slot] = '0;
            soonest_due  = min_armed_due();
        end

        if (hits == 0)
        begin
            b = '{fired: 1'b0, slot: '0, now: clock_ms, last: 1'b1};
            due_beats.push_back(b);
        end
        else
            due_beats[$].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fire_beat_t want;
        if (!rst_n)
        begin
            clock_ms    = '0;
            soonest_due = ALL_ONES;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                armed[i]  = 1'b0;
                due_at[i] = '0;
            end
            due_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
            begin
                if (due_beats.size() == 0)
                begin
                    $error("event beat with nothing expected: fired=%0d index=%0d time=%0d",
                           evt.fired, evt.fired_index, evt.current_time);
                    err_total++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    check_field("fired", TIME_W'(want.fired), TIME_W'(evt.fired));
                    check_field("fired_index", TIME_W'(want.slot), TIME_W'(evt.fired_index));
                    check_field("current_time", want.now, evt.current_time);
                    check_field("last", TIME_W'(want.last), TIME_W'(evt.last));
                end
            end
            if (cmd.valid && cmd.ready)
                apply_cmd(cmd.mode, cmd.timer_index, cmd.amount);
            outstanding <= due_beats.size();
        end
        mismatches <= err_total;
    end

endmodule

[test/tb_one_shot_timer_bank.sv]
`timescale 1ns / 1ps

module tb_one_shot_timer_bank;
    import ostb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam int RANDOM_CMDS  = 155;
    localparam int CALM_TAIL    = 30;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    logic calm = 1'b0;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;

    ostb_cmd_if cmd_bus();
    ostb_evt_if evt_bus();

    one_shot_timer_bank u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .evt   (evt_bus)
    );

    fired_event_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_bus),
        .evt         (evt_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Valid stays high from one beat to the next; only a gap lowers it.
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [TIDX_W-1:0] slot,
                         input logic [TIME_W-1:0] amount);
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= mode;
        cmd_bus.timer_index <= slot;
        cmd_bus.amount      <= amount;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Mostly short spans so deadlines actually get hit; now and then anything.
    function automatic logic [TIME_W-1:0] pick_amount(int span);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 10 * span);
            default: return $urandom_range(0, span);
        endcase
    endfunction

    task automatic random_cmd();
        int                r;
        logic [TIDX_W-1:0] slot;
        r    = $urandom_range(0, 99);
        slot = TIDX_W'($urandom_range(0, 7));
        maybe_gap();
        if (r < 45)
            issue(MODE_TICK, slot, pick_amount(30));
        else if (r < 80)
            issue(MODE_ARM, slot, pick_amount(120));
        else if (r < 95)
            issue(MODE_CANCEL, slot, pick_amount(120));
        else
            issue(MODE_NONE, slot, $urandom);
    endtask

    initial
    begin
        evt_bus.ready <= 1'b0;
        repeat (10) @(posedge clk);
        forever
        begin
            evt_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 1)
            begin
                evt_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.mode        <= MODE_TICK;
        cmd_bus.timer_index <= '0;
        cmd_bus.amount      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // idle tick, then a zero-delay timer fired by a zero tick
        issue(MODE_TICK, '0, 0);
        issue(MODE_ARM, '0, 0);
        issue(MODE_TICK, '0, 0);
        // all timers expire on one tick
        for (int i = 0; i < 8; i++)
            issue(MODE_ARM, TIDX_W'(i), 5);
        maybe_gap();
        issue(MODE_TICK, '0, 5);
        // rearm, cancel armed and unarmed, then nothing left to fire
        issue(MODE_ARM, TIDX_W'(3), 10);
        issue(MODE_ARM, TIDX_W'(3), 20);
        issue(MODE_CANCEL, TIDX_W'(3), 0);
        issue(MODE_CANCEL, TIDX_W'(5), ALL_ONES);
        issue(MODE_TICK, '0, 30);
        issue(MODE_NONE, TIDX_W'(7), ALL_ONES);
        // deadline wraps behind the clock, fires on the next tick
        issue(MODE_ARM, TIDX_W'(7), ALL_ONES);
        issue(MODE_TICK, '0, 0);
        issue(MODE_TICK, '0, ALL_ONES);
        // two deadlines reached on separate ticks
        issue(MODE_ARM, TIDX_W'(2), 100);
        issue(MODE_ARM, TIDX_W'(4), 50);
        maybe_gap();
        issue(MODE_TICK, '0, 60);
        issue(MODE_TICK, '0, 40);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n == RANDOM_CMDS - CALM_TAIL)
                calm = 1'b1;
            random_cmd();
        end
        cmd_bus.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
